@@ rtl/pulse_oximeter_hr_spo2_unit_macros.svh @@
// Assertion macros used by the checker file.
// Depends on nothing; included by pohs_checker.sv.
`ifndef PULSE_OXIMETER_HR_SPO2_UNIT_MACROS_SVH
`define PULSE_OXIMETER_HR_SPO2_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define POHS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// Implication checked on every clock edge, reset included.
`define POHS_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`endif

@@ rtl/pohs_pkg.sv @@
// Package for the pulse oximeter unit: field widths, ratio constants, types.
// Used by pohs_div and the pulse_oximeter_hr_spo2_unit top level.
`timescale 1ns / 1ps
package pohs_pkg;
  localparam int unsigned SampleW = 18;
  localparam int unsigned DropW = 19;
  localparam int unsigned HrW = 8;
  localparam int unsigned SpoW = 7;
  // Smoothing length; a power of two so the mean is a shift
  localparam int unsigned FiltTaps = 8;
  localparam int unsigned FiltShift = $clog2(FiltTaps);
  localparam logic [16:0] Q036 = 17'd23593;
  localparam logic [16:0] Q066 = 17'd43254;
  localparam logic [16:0] QOne = 17'd65536;
  localparam logic [23:0] Lin1Base = 24'd7012352;
  localparam logic [23:0] Lin2Base = 24'd8496087;
  localparam logic [2:0] REG_PRESENCE = 3'd0;
  localparam logic [2:0] REG_DROP = 3'd1;
  localparam logic [2:0] REG_MINBEAT = 3'd2;
  localparam logic [2:0] REG_SCALE = 3'd3;

  // Request to the shared divider
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
  } div_rsp_t;

  // SpO2 from a Q1.16 ratio; valid flag clear when out of range
  function automatic logic [7:0] spo2_map(input logic [63:0] rq);
    logic [23:0] p;
    logic [7:0]  r;
    begin
      r = 8'd0;
      p = 24'd0;
      if (rq >= 64'(Q036) && rq < 64'(Q066)) begin
        p = Lin1Base - 24'(rq[16:0]) * 24'd20;
        r = {1'b1, p[22:16]};
      end else if (rq >= 64'(Q066) && rq < 64'(QOne)) begin
        p = Lin2Base - 24'(rq[16:0]) * 24'd54;
        r = {1'b1, p[22:16]};
      end
      spo2_map = r;
    end
  endfunction
endpackage

@@ rtl/pohs_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module pohs_ram #(
  parameter int unsigned WIDTH = 36,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read one address a cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

@@ rtl/pohs_div.sv @@
// Shared restoring divider, one quotient bit per cycle, 64-bit operands.
// Depends on pohs_pkg.
`timescale 1ns / 1ps
module pohs_div
  import pohs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);
  logic [63:0] quo;
  logic [63:0] den;
  logic [64:0] rem;
  logic [6:0]  cnt;
  logic        busy;
  logic        done;
  logic [64:0] trial;

  assign trial = {rem[63:0], quo[63]} - {1'b0, den};

  // Shift one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= 7'd64;
        quo <= req.num;
        den <= req.den;
        rem <= '0;
      end else if (busy) begin
        if (!trial[64]) begin
          rem <= trial;
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= {rem[63:0], quo[63]};
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign rsp = '{done: done, quo: quo};
endmodule

@@ rtl/pulse_oximeter_hr_spo2_unit.sv @@
// Pulse oximeter: pulse rate and SpO2 from red/infrared samples; uses pohs_pkg, pohs_ram, pohs_div.
// Steps: an absent finger goes straight to a zero result; else a sweep of the window through
// one RAM port, two passes through the 64-step divider, and one output state.
// One item is in flight at a time; the result must be taken before the next item is accepted.
// Reset: synchronous; windows read as zero via a fill count, no clear pass.
`timescale 1ns / 1ps
module pulse_oximeter_hr_spo2_unit
  import pohs_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 50,
  parameter int unsigned BEAT_HISTORY_DEPTH = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // red_level[17:0], infrared_level[35:18]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // pulse_rate[7:0], oxygen_saturation[14:8], infrared_drop[33:15]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int unsigned AW = $clog2(WINDOW_DEPTH);
  localparam int unsigned SumW = SampleW + FiltShift + 1;
  localparam int unsigned HsW = 8 + $clog2(BEAT_HISTORY_DEPTH) + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DIV1 = 3'd2;
  localparam logic [2:0] S_DIV2 = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [17:0] presence_threshold;
  logic [15:0] beat_drop_threshold;
  logic [7:0]  min_beat_samples;
  logic [15:0] hr_scale;

  logic [2:0]  state;
  logic [AW-1:0] head;
  logic [AW:0]   fill;
  logic [AW:0]   idx;
  logic          rd_ok;
  logic [AW:0]   rd_age;
  logic [17:0] rhi, rlo, ihi, ilo;
  logic [SumW-1:0] fsum;
  logic [7:0]  hist [BEAT_HISTORY_DEPTH];
  logic [7:0]  since;
  logic [17:0] last_filt;
  logic [7:0]  held_hr;
  logic [6:0]  held_spo;
  logic [18:0] drop;
  logic        beat;
  logic [HsW-1:0] hsum;

  logic          we;
  logic [AW-1:0] addr;
  logic [35:0]   rdata;
  logic [AW-1:0] rd_addr;
  div_req_t dreq;
  div_rsp_t drsp;

  logic [18:0] rac, iac;
  logic [17:0] rdc, idc;
  logic [18:0] rsum, isum;
  logic [17:0] filt;
  logic [7:0]  sp;
  logic [17:0] rv, iv;

  pohs_ram #(.WIDTH(36), .DEPTH(WINDOW_DEPTH)) u_win (
    .clk(clk), .we(we), .addr(addr), .wdata(s_tdata[35:0]), .rdata(rdata)
  );
  pohs_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign pready = 1'b1;
  assign s_tready = (state == S_IDLE) && !m_tvalid;

  // APB register write and read
  always_ff @(posedge clk) begin
    if (rst) begin
      presence_threshold <= 18'd40000;
      beat_drop_threshold <= 16'd50;
      min_beat_samples <= 8'd12;
      hr_scale <= 16'd30000;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_PRESENCE[1:0]: presence_threshold <= pwdata[17:0];
        REG_DROP[1:0]:     beat_drop_threshold <= pwdata[15:0];
        REG_MINBEAT[1:0]:  min_beat_samples <= pwdata[7:0];
        default:           hr_scale <= pwdata[15:0];
      endcase
    end
  end
  always_comb begin
    unique case (paddr[3:2])
      REG_PRESENCE[1:0]: prdata = {14'd0, presence_threshold};
      REG_DROP[1:0]:     prdata = {16'd0, beat_drop_threshold};
      REG_MINBEAT[1:0]:  prdata = {24'd0, min_beat_samples};
      default:           prdata = {16'd0, hr_scale};
    endcase
  end

  // RAM address: newest write at head, sweep reads age idx
  assign rd_addr = (AW'(idx) <= head) ? AW'(head - AW'(idx))
                                       : AW'(head + AW'(WINDOW_DEPTH) - AW'(idx));
  assign we = (state == S_IDLE) && s_tvalid && s_tready &&
              (s_tdata[35:18] >= presence_threshold);
  assign addr = (state == S_IDLE) ? ((head == AW'(WINDOW_DEPTH - 1)) ? '0 : head + 1'b1)
                                  : rd_addr;
  assign rv = (rd_age < fill) ? rdata[17:0] : 18'd0;
  assign iv = (rd_age < fill) ? rdata[35:18] : 18'd0;

  assign rac = {1'b0, rhi} - {1'b0, rlo};
  assign iac = {1'b0, ihi} - {1'b0, ilo};
  assign rsum = {1'b0, rhi} + {1'b0, rlo};
  assign isum = {1'b0, ihi} + {1'b0, ilo};
  assign rdc = rsum[18:1];
  assign idc = isum[18:1];
  assign filt = 18'(fsum >> FiltShift);
  assign sp = spo2_map(drsp.quo);

  always_comb begin
    hsum = HsW'(since);
    for (int k = 0; k < BEAT_HISTORY_DEPTH - 1; k++) begin
      hsum = hsum + HsW'(hist[k]);
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
      head <= '0;
      fill <= '0;
      since <= '0;
      last_filt <= '0;
      held_hr <= '0;
      held_spo <= '0;
      dreq.start <= 1'b0;
      for (int k = 0; k < BEAT_HISTORY_DEPTH; k++) hist[k] <= '0;
    end else begin
      dreq.start <= 1'b0;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            if (!we) begin
              held_hr <= '0;
              held_spo <= '0;
              m_tdata <= '0;
              m_tvalid <= 1'b1;
            end else begin
              head <= addr;
              if (fill != (AW+1)'(WINDOW_DEPTH)) fill <= fill + 1'b1;
              rhi <= s_tdata[17:0];
              rlo <= s_tdata[17:0];
              ihi <= s_tdata[35:18];
              ilo <= s_tdata[35:18];
              fsum <= SumW'(s_tdata[35:18]);
              idx <= '0;
              rd_ok <= 1'b0;
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // Read one entry a cycle; data arrives next cycle, the oldest one after the last read
          if (rd_ok) begin
            if (rv > rhi) rhi <= rv;
            if (rv < rlo) rlo <= rv;
            if (iv > ihi) ihi <= iv;
            if (iv < ilo) ilo <= iv;
            if (rd_age < (AW+1)'(FiltTaps - 1)) fsum <= fsum + SumW'(iv);
          end
          rd_age <= idx;
          rd_ok <= (idx < (AW+1)'(WINDOW_DEPTH));
          if (idx <= (AW+1)'(WINDOW_DEPTH)) begin
            idx <= idx + 1'b1;
          end else begin
            dreq.start <= 1'b1;
            dreq.num <= {12'd0, 36'(rac[17:0]) * 36'(idc), 16'd0};
            dreq.den <= (rdc == 0 || iac == 0 || idc == 0) ? 64'd0
                        : {28'd0, 36'(rdc) * 36'(iac[17:0])};
            state <= S_DIV1;
          end
        end
        S_DIV1: begin
          if (drsp.done) begin
            if (dreq.den != 0 && sp[7]) held_spo <= sp[6:0];
            drop <= {1'b0, last_filt} - {1'b0, filt};
            beat <= ($signed({1'b0, last_filt} - {1'b0, filt}) >
                     $signed({3'b0, beat_drop_threshold})) && (since > min_beat_samples);
            dreq.start <= 1'b1;
            dreq.num <= 64'(hr_scale);
            dreq.den <= 64'(hsum);
            state <= S_DIV2;
          end
        end
        S_DIV2: begin
          if (drsp.done) state <= S_OUT;
        end
        default: begin
          last_filt <= filt;
          if (beat) begin
            hist[0] <= since;
            for (int k = 1; k < BEAT_HISTORY_DEPTH; k++) hist[k] <= hist[k-1];
            held_hr <= (dreq.den == 0) ? 8'd255
                       : (drsp.quo > 64'd255) ? 8'd255 : drsp.quo[7:0];
            since <= 8'd1;
            m_tdata <= {6'd0, drop, held_spo,
                        (dreq.den == 0) ? 8'd255
                        : (drsp.quo > 64'd255) ? 8'd255 : drsp.quo[7:0]};
          end else begin
            since <= since + 8'd1;
            m_tdata <= {6'd0, drop, held_spo, held_hr};
          end
          m_tvalid <= 1'b1;
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

@@ rtl/pohs_checker.sv @@
// Port-level checker for the pulse oximeter unit, bound to the top level.
// Depends on pulse_oximeter_hr_spo2_unit_macros.svh.
`timescale 1ns / 1ps
`include "pulse_oximeter_hr_spo2_unit_macros.svh"
module pohs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        pready
);
  `POHS_ASSERT(a_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
  `POHS_ASSERT(a_busy, clk, rst, m_tvalid |-> !s_tready)
  `POHS_ASSERT(a_one, clk, rst, s_tvalid && s_tready |=> !s_tready)
  `POHS_ASSERT(a_spo, clk, rst, m_tvalid |-> m_tdata[14:8] <= 7'd99)
  `POHS_ASSERT_ALWAYS(a_rdy, clk, pready)
endmodule

bind pulse_oximeter_hr_spo2_unit pohs_checker u_chk (.*);

@@ sim/tb.sv @@
// Self-checking testbench for pulse_oximeter_hr_spo2_unit: streams red/infrared
// sample items, predicts heart rate, SpO2 and infrared drop, and checks each result.
// Depends on pohs_pkg and the RTL of the block.
`timescale 1ns / 1ps
module tb;
  import pohs_pkg::*;

  localparam int WinDepth = 50;
  localparam int SmoothTaps = 8;
  localparam int HistDepth = 10;
  localparam int Settle = 300;
  localparam longint CycleLimit = 4000000;

  typedef struct packed {
    logic [7:0]  hr;
    logic [6:0]  spo;
    logic [18:0] drop;
  } vitals_t;

  typedef struct {
    logic [17:0] red;
    logic [17:0] ir;
    bit          typed;
    vitals_t     want;
  } sample_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;  // red_level[17:0], infrared_level[35:18]
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;  // pulse_rate[7:0], oxygen_saturation[14:8], infrared_drop[33:15]
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pulse_oximeter_hr_spo2_unit dut (.*);

  always #6 clk = ~clk;

  // Predictor state
  logic [17:0] cfg_presence;
  logic [15:0] cfg_drop_thr;
  logic [7:0]  cfg_min_beat;
  logic [15:0] cfg_hr_scale;
  logic [17:0] red_win [WinDepth];
  logic [17:0] ir_win [WinDepth];
  logic [7:0]  interval_hist [HistDepth];
  logic [7:0]  since_beat;
  logic [17:0] last_filt;
  logic [7:0]  held_hr;
  logic [6:0]  held_spo;

  vitals_t     vitals_q[$];
  int          errors = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          beats_seen = 0;
  int          absent_seen = 0;
  longint      cycles = 0;
  int          burst_left = 0;
  bit          hold_req = 0;

  function automatic void reset_predictor();
    cfg_presence = 18'd40000;
    cfg_drop_thr = 16'd50;
    cfg_min_beat = 8'd12;
    cfg_hr_scale = 16'd30000;
    foreach (red_win[i]) begin
      red_win[i] = '0;
      ir_win[i] = '0;
    end
    foreach (interval_hist[i]) interval_hist[i] = '0;
    since_beat = '0;
    last_filt = '0;
    held_hr = '0;
    held_spo = '0;
  endfunction

  // Ratio-of-ratios SpO2 and beat-interval heart rate for one sample pair
  function automatic vitals_t predict_vitals(input logic [17:0] red, input logic [17:0] ir);
    vitals_t v;
    longint rhi, rlo, ihi, ilo, rac, rdc, iac, idc, filt, rq, total, rate;
    int d;
    v = '0;
    if (ir < cfg_presence) begin
      held_hr = '0;
      held_spo = '0;
      absent_seen++;
      return v;
    end
    for (int i = WinDepth - 1; i > 0; i--) begin
      red_win[i] = red_win[i-1];
      ir_win[i] = ir_win[i-1];
    end
    red_win[0] = red;
    ir_win[0] = ir;
    rhi = red_win[0]; rlo = red_win[0]; ihi = ir_win[0]; ilo = ir_win[0];
    for (int i = 1; i < WinDepth; i++) begin
      if (red_win[i] > rhi) rhi = red_win[i];
      if (red_win[i] < rlo) rlo = red_win[i];
      if (ir_win[i] > ihi) ihi = ir_win[i];
      if (ir_win[i] < ilo) ilo = ir_win[i];
    end
    rac = rhi - rlo; rdc = (rhi + rlo) >> 1;
    iac = ihi - ilo; idc = (ihi + ilo) >> 1;
    filt = ir;
    for (int i = 0; i < SmoothTaps - 1; i++) filt += ir_win[i];
    filt = filt / SmoothTaps;
    // Hold SpO2 on a zero divisor or a ratio outside the mapped range
    if (rdc != 0 && iac != 0 && idc != 0) begin
      rq = ((rac * idc) << 16) / (rdc * iac);
      if (rq >= 23593 && rq < 43254)
        held_spo = 7'((7012352 - 20 * rq) >> 16);
      else if (rq >= 43254 && rq < 65536)
        held_spo = 7'((8496087 - 54 * rq) >> 16);
    end
    d = int'(last_filt) - int'(filt);
    if (d > int'(cfg_drop_thr) && since_beat > cfg_min_beat) begin
      for (int k = HistDepth - 1; k > 0; k--) interval_hist[k] = interval_hist[k-1];
      interval_hist[0] = since_beat;
      total = 0;
      foreach (interval_hist[k]) total += interval_hist[k];
      rate = (total != 0) ? cfg_hr_scale / total : 255;
      held_hr = (rate > 255) ? 8'd255 : 8'(rate);
      since_beat = '0;
      beats_seen++;
    end
    last_filt = 18'(filt);
    since_beat = since_beat + 8'd1;
    v.hr = held_hr;
    v.spo = held_spo;
    v.drop = 19'(d);
    return v;
  endfunction

  // Offer one item, hold it until taken, then apply the burst/gap pattern
  task automatic send_sample(input logic [17:0] red, input logic [17:0] ir,
                             input bit typed, input vitals_t want);
    vitals_t v;
    int gap;
    s_tvalid <= 1'b1;
    s_tdata <= {4'b0, ir, red};
    do @(posedge clk); while (!s_tready);
    v = predict_vitals(red, ir);
    vitals_q.push_back(typed ? want : v);
    items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stop sending and wait until every expected result has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (vitals_q.size() != 0) @(posedge clk);
    repeat (Settle) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 4'(idx) << 2;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_PRESENCE: cfg_presence = val[17:0];
      REG_DROP:     cfg_drop_thr = val[15:0];
      REG_MINBEAT:  cfg_min_beat = val[7:0];
      REG_SCALE:    cfg_hr_scale = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [31:0] pres, input logic [31:0] dthr,
                            input logic [31:0] minb, input logic [31:0] scale);
    apb_write(REG_PRESENCE, pres);
    apb_write(REG_DROP, dthr);
    apb_write(REG_MINBEAT, minb);
    apb_write(REG_SCALE, scale);
  endtask

  function automatic logic [17:0] clamp18(input longint x);
    if (x < 0) return '0;
    if (x > 262143) return 18'h3FFFF;
    return 18'(x);
  endfunction

  // One random run: mostly sawtooth pulse waveforms, some flat, absent or noise
  task automatic send_run(input int budget, inout int sent);
    int kind, len, period, phase;
    longint ir_base, ir_amp, red_base, red_amp, lo;
    vitals_t none;
    none = '0;
    kind = $urandom_range(0, 11);
    len = $urandom_range(20, 160);
    if (kind == 2 && $urandom_range(0, 2) == 0) len = $urandom_range(260, 320);
    if (len > budget - sent) len = budget - sent;
    if (len < 1) len = 1;
    period = $urandom_range(14, 60);
    phase = 0;
    ir_amp = $urandom_range(100, 30000);
    red_amp = $urandom_range(50, 30000);
    lo = cfg_presence;
    if (lo > 262143 - ir_amp) lo = 262143 - ir_amp;
    ir_base = $urandom_range(int'(lo), 262143 - int'(ir_amp));
    red_base = $urandom_range(0, 262143 - int'(red_amp));
    for (int n = 0; n < len; n++) begin
      case (kind)
        0: send_sample(18'($urandom_range(0, 262143)), 18'($urandom_range(0, 262143)),
                       0, none);
        1: send_sample(18'($urandom_range(0, 262143)),
                       (cfg_presence == 0) ? 18'd0
                                           : 18'($urandom_range(0, cfg_presence - 1)),
                       0, none);
        2: send_sample(18'(red_base), 18'(ir_base), 0, none);
        default: begin
          send_sample(clamp18(red_base + red_amp * phase / period),
                      clamp18(ir_base + ir_amp * phase / period
                              + (($urandom_range(0, 30) == 0) ? -longint'(ir_amp) : 0)),
                      0, none);
        end
      endcase
      phase = (phase + 1) % period;
      sent++;
    end
  endtask

  task automatic random_phase(input int count);
    int sent;
    sent = 0;
    while (sent < count) send_run(count, sent);
  endtask

  // Directed table: typed rows are absent-finger cases, the rest use the predictor
  sample_row_t rows[] = '{
    '{18'd0,      18'd0,      1, '0},
    '{18'h3FFFF,  18'd39999,  1, '0},
    '{18'h3FFFF,  18'h3FFFF,  0, '0},
    '{18'd0,      18'h3FFFF,  0, '0},
    '{18'h3FFFF,  18'd40000,  0, '0},
    '{18'd1,      18'd50000,  0, '0},
    '{18'd0,      18'd0,      1, '0},
    '{18'd131072, 18'd131072, 0, '0},
    '{18'd65535,  18'd100000, 0, '0},
    '{18'h2AAAA,  18'h15555,  0, '0},
    '{18'h15555,  18'h2AAAA,  0, '0},
    '{18'd100000, 18'd200000, 0, '0},
    '{18'd90000,  18'd190000, 0, '0},
    '{18'd80000,  18'd60000,  0, '0},
    '{18'd200000, 18'd39999,  1, '0},
    '{18'd120000, 18'd150000, 0, '0}
  };

  // Stimulus and configuration phases
  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    reset_predictor();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) send_sample(rows[i].red, rows[i].ir, rows[i].typed, rows[i].want);
    random_phase(250);
    drain();
    set_config(32'd0, 32'd0, 32'd0, 32'd1);
    random_phase(300);
    drain();
    set_config(32'd262143, 32'd65535, 32'd255, 32'd65535);
    random_phase(80);
    drain();
    set_config($urandom_range(0, 60000), $urandom_range(0, 400),
               $urandom_range(0, 40), $urandom_range(1, 65535));
    hold_req = 1'b1;
    random_phase(300);
    drain();
    set_config(32'd1000, 32'd20, 32'd5, 32'd65535);
    random_phase(300);
    drain();
    set_config(32'd40000, 32'd50, 32'd12, 32'd30000);
    random_phase(250);
    drain();
    $display("Covered %0d items, %0d results, %0d beats, %0d absent-finger items.",
             items_sent, results_seen, beats_seen, absent_seen);
    $display("Register settings swept through defaults, both extremes and random values.");
    if (errors == 0) begin
      $display("PASS pulse_oximeter_hr_spo2_unit");
    end else begin
      $display("FAIL pulse_oximeter_hr_spo2_unit");
    end
    $finish;
  end

  // Receiver: switch among stall patterns, plus one long hold-off on request
  initial begin
    int stall_left, mode;
    stall_left = 0;
    mode = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (cycles % 3000 == 0) mode = $urandom_range(0, 2);
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = 3000;
        m_tready <= 1'b0;
      end else begin
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= $urandom_range(0, 1);
          default: m_tready <= (cycles % 7 == 0);
        endcase
      end
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    vitals_t got, exp_v;
    cycles <= cycles + 1;
    if (!rst && m_tvalid && m_tready) begin
      got = '{hr: m_tdata[7:0], spo: m_tdata[14:8], drop: m_tdata[33:15]};
      results_seen++;
      if (vitals_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: hr %0d spo2 %0d drop %0h",
                 $time, got.hr, got.spo, got.drop);
      end else begin
        exp_v = vitals_q.pop_front();
        if (got.hr !== exp_v.hr) begin
          errors++;
          $display("%0t: pulse rate expected %0d actual %0d", $time, exp_v.hr, got.hr);
        end
        if (got.spo !== exp_v.spo) begin
          errors++;
          $display("%0t: oxygen_saturation expected %0d actual %0d",
                   $time, exp_v.spo, got.spo);
        end
        if (got.drop !== exp_v.drop) begin
          errors++;
          $display("%0t: infrared_drop expected %0h actual %0h",
                   $time, exp_v.drop, got.drop);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (cycles >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results pending", cycles, vitals_q.size());
      $display("FAIL pulse_oximeter_hr_spo2_unit");
      $finish;
    end
  end
endmodule

@@ files.f @@
+incdir+rtl
rtl/pohs_pkg.sv
rtl/pohs_ram.sv
rtl/pohs_div.sv
rtl/pulse_oximeter_hr_spo2_unit.sv
rtl/pohs_checker.sv
sim/tb.sv
